[rtl/dnrt_pkg.sv]
// Shared types, codes and defaults for the digest nonce replay table.
`timescale 1ns / 1ps
`default_nettype none

package dnrt_pkg;

    localparam int DEF_ENTRIES    = 64;
    localparam int DEF_COUNT_BITS = 64;

    localparam logic [15:0] TIMEOUT_RESET = 16'd60;
    localparam logic [15:0] EXPIRES_RESET = 16'd10;
    localparam logic [5:0]  REPLAYS_RESET = 6'd20;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPIRES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLAYS = 2'd2;

    localparam logic [1:0] REQ_ISSUE  = 2'd0;
    localparam logic [1:0] REQ_VERIFY = 2'd1;
    localparam logic [1:0] REQ_PRUNE  = 2'd2;

    localparam logic [2:0] STAT_ISSUED  = 3'd0;
    localparam logic [2:0] STAT_COLLIDE = 3'd1;
    localparam logic [2:0] STAT_FULL    = 3'd2;
    localparam logic [2:0] STAT_ACCEPT  = 3'd3;
    localparam logic [2:0] STAT_STALE   = 3'd4;
    localparam logic [2:0] STAT_REJECT  = 3'd5;
    localparam logic [2:0] STAT_PRUNED  = 3'd6;

    localparam logic [6:0] REMOVED_MAX = 7'd127;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] nonce_key;
        logic [15:0] use_count;
        logic [31:0] now_secs;
    } in_t;

    typedef struct packed {
        logic [2:0] status;
        logic [6:0] removed_count;
    } out_t;

    typedef struct packed {
        logic [15:0] timeout_secs;
        logic [15:0] expires_secs;
        logic [5:0]  replays;
    } cfg_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FINISH
    } ctrl_state_t;

endpackage

`default_nettype wire

[rtl/dnrt_ram.sv]
// Session table memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module dnrt_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 129,
    parameter int AW    = 6
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/dnrt_ctrl.sv]
// Sequencer that walks the session table one entry a cycle for each request that needs a lookup.
`timescale 1ns / 1ps
`default_nettype none

module dnrt_ctrl
    import dnrt_pkg::*;
#(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int COUNT_BITS = DEF_COUNT_BITS,
    parameter int AW         = $clog2(ENTRIES),
    parameter int EW         = COUNT_BITS + 65
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire in_t           in_data,
    input  wire cfg_t          cfg,
    input  wire logic          res_take,
    output logic               res_valid,
    output out_t               res,
    output logic               ram_we,
    output logic [AW-1:0]      ram_waddr,
    output logic [EW-1:0]      ram_wdata,
    output logic               ram_re,
    output logic [AW-1:0]      ram_raddr,
    input  wire logic [EW-1:0] ram_rdata
);

    localparam int CW      = AW + 1;
    localparam int BW      = $clog2(COUNT_BITS);
    localparam int EXP_LSB = COUNT_BITS;
    localparam int KEY_LSB = COUNT_BITS + 32;
    localparam int VLD_BIT = COUNT_BITS + 64;

    ctrl_state_t           state_reg, state_next;
    in_t                   req_reg, req_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic                  data_vld_reg, data_vld_next;
    logic [AW-1:0]         data_idx_reg, data_idx_next;
    logic                  free_found_reg, free_found_next;
    logic [AW-1:0]         free_idx_reg, free_idx_next;
    logic [2:0]            status_reg, status_next;
    logic [6:0]            removed_reg, removed_next;

    logic                  rd_valid;
    logic [31:0]           rd_key;
    logic [31:0]           rd_expiry;
    logic [COUNT_BITS-1:0] rd_unused;
    logic [COUNT_BITS-1:0] new_unused;
    logic [31:0]           new_expiry;
    logic [BW-1:0]         bit_idx;
    logic [15:0]           limit;
    logic                  key_hit;
    logic                  last;

    assign rd_valid  = ram_rdata[VLD_BIT];
    assign rd_key    = ram_rdata[KEY_LSB +: 32];
    assign rd_expiry = ram_rdata[EXP_LSB +: 32];
    assign rd_unused = ram_rdata[COUNT_BITS-1:0];
    assign bit_idx   = req_reg.use_count[BW-1:0];
    assign key_hit   = rd_valid && (rd_key == req_reg.nonce_key);
    assign last      = data_idx_reg == AW'(ENTRIES - 1);
    assign limit     = ({10'd0, cfg.replays} > 16'(COUNT_BITS)) ? 16'(COUNT_BITS)
                                                              : {10'd0, cfg.replays};
    assign res       = '{status: status_reg, removed_count: removed_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            idx_reg        <= '0;
            data_vld_reg   <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            data_vld_reg   <= data_vld_next;
            free_found_reg <= free_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        data_idx_reg <= data_idx_next;
        free_idx_reg <= free_idx_next;
        status_reg   <= status_next;
        removed_reg  <= removed_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        idx_next        = idx_reg;
        data_vld_next   = 1'b0;
        data_idx_next   = data_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        status_next     = status_reg;
        removed_next    = removed_reg;
        in_ready        = 1'b0;
        res_valid       = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = data_idx_reg;
        ram_wdata       = ram_rdata;
        ram_re          = 1'b0;
        ram_raddr       = idx_reg[AW-1:0];
        new_unused      = rd_unused;
        new_expiry      = rd_expiry;

        unique case (state_reg)
            S_CLEAR:
            begin
                // Sweep every entry to invalid before taking requests
                ram_we    = 1'b1;
                ram_waddr = idx_reg[AW-1:0];
                ram_wdata = '0;
                idx_next  = idx_reg + CW'(1);
                if (idx_reg == CW'(ENTRIES - 1))
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    req_next        = in_data;
                    idx_next        = '0;
                    free_found_next = 1'b0;
                    removed_next    = '0;
                    case (in_data.req_type)
                        REQ_ISSUE, REQ_PRUNE:
                        begin
                            state_next = S_SCAN;
                        end
                        REQ_VERIFY:
                        begin
                            if (in_data.use_count >= limit)
                            begin
                                status_next = STAT_STALE;
                                state_next  = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            status_next = STAT_REJECT;
                            state_next  = S_FINISH;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // Issue the next read while the previous entry is evaluated
                if (idx_reg < CW'(ENTRIES))
                begin
                    ram_re        = 1'b1;
                    idx_next      = idx_reg + CW'(1);
                    data_vld_next = 1'b1;
                    data_idx_next = idx_reg[AW-1:0];
                end

                if (data_vld_reg)
                begin
                    case (req_reg.req_type)
                        REQ_ISSUE:
                        begin
                            if (key_hit)
                            begin
                                status_next   = STAT_COLLIDE;
                                state_next    = S_FINISH;
                                data_vld_next = 1'b0;
                            end
                            else
                            begin
                                if (!rd_valid && !free_found_reg)
                                begin
                                    free_found_next = 1'b1;
                                    free_idx_next   = data_idx_reg;
                                end
                                if (last)
                                begin
                                    state_next    = S_FINISH;
                                    data_vld_next = 1'b0;
                                    if (free_found_reg || !rd_valid)
                                    begin
                                        ram_we      = 1'b1;
                                        ram_waddr   = free_found_reg ? free_idx_reg
                                                                     : data_idx_reg;
                                        new_expiry  = req_reg.now_secs
                                                    + {16'd0, cfg.timeout_secs};
                                        ram_wdata   = {1'b1, req_reg.nonce_key, new_expiry,
                                                       {COUNT_BITS{1'b1}}};
                                        status_next = STAT_ISSUED;
                                    end
                                    else
                                    begin
                                        status_next = STAT_FULL;
                                    end
                                end
                            end
                        end

                        REQ_VERIFY:
                        begin
                            if (key_hit)
                            begin
                                state_next    = S_FINISH;
                                data_vld_next = 1'b0;
                                if (rd_unused[bit_idx])
                                begin
                                    // First use moves the expiry to the short lifetime
                                    if (rd_unused[0])
                                    begin
                                        new_unused[0] = 1'b0;
                                        new_expiry    = req_reg.now_secs
                                                      + {16'd0, cfg.expires_secs};
                                    end
                                    new_unused[bit_idx] = 1'b0;
                                    ram_we      = 1'b1;
                                    ram_wdata   = {1'b1, rd_key, new_expiry, new_unused};
                                    status_next = STAT_ACCEPT;
                                end
                                else
                                begin
                                    status_next = STAT_REJECT;
                                end
                            end
                            else if (last)
                            begin
                                status_next   = STAT_REJECT;
                                state_next    = S_FINISH;
                                data_vld_next = 1'b0;
                            end
                        end

                        default:
                        begin
                            if (rd_valid && (rd_expiry <= req_reg.now_secs))
                            begin
                                ram_we    = 1'b1;
                                ram_wdata = {1'b0, rd_key, rd_expiry, rd_unused};
                                if (removed_reg != REMOVED_MAX)
                                begin
                                    removed_next = removed_reg + 7'd1;
                                end
                            end
                            if (last)
                            begin
                                status_next = STAT_PRUNED;
                                state_next  = S_FINISH;
                            end
                        end
                    endcase
                end
            end

            S_FINISH:
            begin
                // Hold until the output register has room
                if (res_take)
                begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("table read and write collide on one entry");

    a_res_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_take)
        else $error("result delivered while output register is full");

    a_data_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        data_vld_reg |-> $past(ram_re))
        else $error("entry evaluated without a preceding read");

    a_removed_only_prune: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.removed_count != 7'd0)) |-> (res.status == STAT_PRUNED))
        else $error("removed count set on a request other than prune");

endmodule

`default_nettype wire

[rtl/digest_nonce_replay_table_unit.sv]
// Top level of the digest nonce replay table: configuration, output register, table.
//
// Requests enter on in_valid/in_ready as an in_t beat: issue, verify or prune,
// with the session key, client count and current time. Each request gives
// exactly one out_t beat on out_valid/out_ready: a status code and, for a
// prune, the number of sessions removed.
// Issue and prune walk the table memory one entry a cycle; a verify, or an
// issue whose key is present, stops at the match. A stale count or an unknown
// request type is answered without a read of the table.
// One request is in work at a time; in_ready is high only between requests.
// The output register holds a finished beat while the receiver stalls, and
// the next request may be taken meanwhile; its result waits in the
// sequencer until the output register drains.
// After reset the table is cleared in a pass over every entry during which
// no request is taken; configuration writes on cfg_we are taken at any time
// and take effect at once. Registers reset to a 60 s timeout, a 10 s expiry
// after first use and 20 count values per session.
`timescale 1ns / 1ps
`default_nettype none

module digest_nonce_replay_table_unit
    import dnrt_pkg::*;
#(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire in_t                   in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output out_t                       out_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int AW = $clog2(ENTRIES);
    localparam int EW = COUNT_BITS + 65;

    cfg_t          cfg_reg;
    logic          out_valid_reg;
    out_t          out_reg;
    logic          res_take;
    logic          res_valid;
    out_t          res;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_secs <= TIMEOUT_RESET;
            cfg_reg.expires_secs <= EXPIRES_RESET;
            cfg_reg.replays      <= REPLAYS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TIMEOUT: cfg_reg.timeout_secs <= cfg_wdata;
                CFG_EXPIRES: cfg_reg.expires_secs <= cfg_wdata;
                CFG_REPLAYS: cfg_reg.replays      <= cfg_wdata[5:0];
                default:     cfg_reg              <= cfg_reg;
            endcase
        end
    end

    assign res_take = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    dnrt_ctrl #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS),
        .AW         (AW),
        .EW         (EW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cfg       (cfg_reg),
        .res_take  (res_take),
        .res_valid (res_valid),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    dnrt_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (EW),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire
